// ===== sv/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types and constants for the cursor array list unit.
// ----------------------------------------------------------------------------
package cal_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // reset value of the max_items register
  localparam logic [4:0] MAX_ITEMS_RESET = 5'd16;

  typedef enum logic [3:0] {
    OP_QUERY    = 4'd0,
    OP_INSERT   = 4'd1,
    OP_APPEND   = 4'd2,
    OP_REMOVE   = 4'd3,
    OP_TO_START = 4'd4,
    OP_TO_END   = 4'd5,
    OP_PREV     = 4'd6,
    OP_NEXT     = 4'd7,
    OP_TO_POS   = 4'd8,
    OP_CLEAR    = 4'd9
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOCUR = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // one result word, as handed from the core to the output register
  typedef struct packed {
    status_t     status;
    logic [31:0] removed_value;
    logic [31:0] current_value;
    logic        current_valid;
    logic [4:0]  item_count;
    logic [4:0]  cursor_position;
    logic        at_end;
    logic        is_empty;
  } result_t;

endpackage

// ===== sv/cal_ram.sv =====
// ----------------------------------------------------------------------------
// cal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/cal_core.sv =====
// ----------------------------------------------------------------------------
// cal_core
// Command sequencer: decodes a command, walks the entry RAM one entry per
// step to open or close a gap, and fetches the entry under the cursor.
// ----------------------------------------------------------------------------
module cal_core #(
  parameter int CAPACITY    = cal_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cal_pkg::VALUE_WIDTH_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [4:0]             max_items,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             opcode,
  input  logic [31:0]            item_value,
  input  logic [4:0]             target_position,
  output logic                   res_valid,
  input  logic                   res_ready,
  output cal_pkg::result_t       res,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [VALUE_WIDTH-1:0] ram_wdata,
  output logic                   ram_re,
  output logic [AW-1:0]          ram_raddr,
  input  logic [VALUE_WIDTH-1:0] ram_rdata
);

  localparam int LW = (CW > 5) ? CW : 5;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SHIFT_RD = 8'b0000_0010,
    S_SHIFT_WR = 8'b0000_0100,
    S_PUT      = 8'b0000_1000,
    S_REM_RD   = 8'b0001_0000,
    S_REM_CAP  = 8'b0010_0000,
    S_FETCH    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          cursor;
  logic [CW-1:0]          idx;
  logic                   shift_up;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] removed;
  cal_pkg::status_t       status;

  logic [LW-1:0]  limit;
  logic           full;
  logic           cur_ok;
  logic           pos_bad;
  logic [CW-1:0]  idx_dec;
  logic [CW-1:0]  idx_inc;
  logic [CW-1:0]  rd_src;
  logic [63:0]    in_wide;
  logic [63:0]    rd_wide;
  logic [63:0]    rem_wide;
  logic [63:0]    cnt_wide;
  logic [63:0]    cur_wide;

  // limit in force is min(max_items, CAPACITY)
  always_comb begin
    limit   = (LW'(max_items) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_items);
    full    = LW'(count) >= limit;
    cur_ok  = cursor < count;
    pos_bad = LW'(target_position) > LW'(count);
    idx_dec = idx - 1'b1;
    idx_inc = idx + 1'b1;
    rd_src  = shift_up ? idx_dec : idx_inc;
    in_wide = 64'(item_value);
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      cursor <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            val      <= in_wide[VALUE_WIDTH-1:0];
            status   <= cal_pkg::ST_OK;
            removed  <= '0;
            idx      <= count;
            shift_up <= 1'b1;
            state    <= S_FETCH;
            case (cal_pkg::opcode_t'(opcode))
              cal_pkg::OP_INSERT: begin
                if (full) begin
                  status <= cal_pkg::ST_FULL;
                end else if (count > cursor) begin
                  state <= S_SHIFT_RD;
                end else begin
                  state <= S_PUT;
                end
              end
              cal_pkg::OP_APPEND: begin
                if (full) begin
                  status <= cal_pkg::ST_FULL;
                end else begin
                  state <= S_PUT;
                end
              end
              cal_pkg::OP_REMOVE: begin
                if (!cur_ok) begin
                  status <= cal_pkg::ST_NOCUR;
                end else begin
                  state <= S_REM_RD;
                end
              end
              cal_pkg::OP_TO_START: cursor <= '0;
              cal_pkg::OP_TO_END:   cursor <= count;
              cal_pkg::OP_PREV: begin
                if (cursor != '0) begin
                  cursor <= cursor - 1'b1;
                end
              end
              cal_pkg::OP_NEXT: begin
                if (cur_ok) begin
                  cursor <= cursor + 1'b1;
                end
              end
              cal_pkg::OP_TO_POS: begin
                if (pos_bad) begin
                  status <= cal_pkg::ST_RANGE;
                end else begin
                  cursor <= CW'(target_position);
                end
              end
              cal_pkg::OP_CLEAR: begin
                count  <= '0;
                cursor <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          if (shift_up) begin
            idx   <= idx_dec;
            state <= (idx_dec > cursor) ? S_SHIFT_RD : S_PUT;
          end else begin
            // count already holds the shortened length here
            idx   <= idx_inc;
            state <= (idx_inc < count) ? S_SHIFT_RD : S_FETCH;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_FETCH;
        end
        S_REM_RD: state <= S_REM_CAP;
        S_REM_CAP: begin
          removed  <= ram_rdata;
          count    <= count - 1'b1;
          idx      <= cursor;
          shift_up <= 1'b0;
          state    <= (CW'(cursor + 1'b1) < count) ? S_SHIFT_RD : S_FETCH;
        end
        S_FETCH: state <= S_DONE;
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // RAM port drive
  always_comb begin
    ram_we    = (state == S_PUT) || (state == S_SHIFT_WR);
    ram_waddr = idx[AW-1:0];
    ram_wdata = (state == S_PUT) ? val : ram_rdata;
    ram_re    = (state == S_SHIFT_RD) || (state == S_REM_RD) ||
                ((state == S_FETCH) && cur_ok);
    ram_raddr = (state == S_SHIFT_RD) ? rd_src[AW-1:0] : cursor[AW-1:0];
  end

  // result word; RAM data still holds the fetch in S_DONE
  always_comb begin
    rd_wide  = 64'(ram_rdata);
    rem_wide = 64'(removed);
    cnt_wide = 64'(count);
    cur_wide = 64'(cursor);
    res_valid           = (state == S_DONE);
    res.status          = status;
    res.removed_value   = rem_wide[31:0];
    res.current_value   = cur_ok ? rd_wide[31:0] : 32'd0;
    res.current_valid   = cur_ok;
    res.item_count      = cnt_wide[4:0];
    res.cursor_position = cur_wide[4:0];
    res.at_end          = (cursor == count);
    res.is_empty        = (count == '0);
  end

endmodule

// ===== sv/cursor_array_list_unit.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list_unit
// Bounded ordered list with a cursor, entries held in a RAM.
// ----------------------------------------------------------------------------
// Entry moves: insert shifts each entry at or past the cursor up and remove
//   shifts each entry past the cursor down, one RAM read/write pair per entry
//   moved; moves, queries, clear, append and failed commands move no entries.
// Throughput: one command in flight; the next is taken once the result is in
//   the output register, which may still be waiting downstream.
// Reset: synchronous; empty list, cursor 0, max_items 16, RAM left as is.
// ----------------------------------------------------------------------------
module cursor_array_list_unit #(
  parameter int CAPACITY    = cal_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cal_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write: max_items
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  // command word
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [31:0] item_value,
  input  logic [4:0]  target_position,
  // result word
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] removed_value,
  output logic [31:0] current_value,
  output logic        current_valid,
  output logic [4:0]  item_count,
  output logic [4:0]  cursor_position,
  output logic        at_end,
  output logic        is_empty
);

  localparam int AW = $clog2(CAPACITY);

  logic [4:0]             max_items;
  logic                   res_valid;
  logic                   res_ready;
  cal_pkg::result_t       res;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // config register is always writable; writes must arrive only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_items <= cal_pkg::MAX_ITEMS_RESET;
    end else if (cfg_valid) begin
      max_items <= cfg_data;
    end
  end

  cal_core #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .max_items       (max_items),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .item_value      (item_value),
    .target_position (target_position),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  cal_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: core may hand over a word when the slot is free or
  // being emptied this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status          <= res.status;
      removed_value   <= res.removed_value;
      current_value   <= res.current_value;
      current_valid   <= res.current_valid;
      item_count      <= res.item_count;
      cursor_position <= res.cursor_position;
      at_end          <= res.at_end;
      is_empty        <= res.is_empty;
    end
  end

endmodule
